>>> rtl/lec_pkg.sv
// ----------------------------------------------------------------------------
// lec_pkg
// shared types and register codes for the line extension core
// ----------------------------------------------------------------------------
package lec_pkg;

	typedef enum logic [1:0] {
		REG_BOX_LEFT   = 2'd0,
		REG_BOX_TOP    = 2'd1,
		REG_BOX_RIGHT  = 2'd2,
		REG_BOX_BOTTOM = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

endpackage

>>> rtl/lec_div.sv
// ----------------------------------------------------------------------------
// lec_div
// pipelined restoring divider, one quotient bit per stage, payload rides along
// ----------------------------------------------------------------------------
module lec_div
	import lec_pkg::*;
#(
	parameter int NW = 50,
	parameter int DW = 25,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pipe_ctl_t     ctl,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay_in,
	output logic          vld_out,
	output logic [NW-1:0] quo,
	output logic [PW-1:0] pay_out
);

	logic [NW-1:0] num_s [NW+1];
	logic [DW-1:0] den_s [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [NW-1:0] quo_s [NW+1];
	logic [PW-1:0] pay_s [NW+1];
	logic          vld_s [NW+1];

	assign num_s[0] = num;
	assign den_s[0] = den;
	assign rem_s[0] = '0;
	assign quo_s[0] = '0;
	assign pay_s[0] = pay_in;
	assign vld_s[0] = ctl.vld;

	for (genvar i = 1; i <= NW; i++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		assign trial = {rem_s[i-1], num_s[i-1][NW-1]};
		assign diff  = trial - {1'b0, den_s[i-1]};
		assign ge    = ~diff[DW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				num_s[i] <= {num_s[i-1][NW-2:0], 1'b0};
				den_s[i] <= den_s[i-1];
				rem_s[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_s[i] <= {quo_s[i-1][NW-2:0], ge};
				pay_s[i] <= pay_s[i-1];
			end
		end
	end

	assign vld_out = vld_s[NW];
	assign quo     = quo_s[NW];
	assign pay_out = pay_s[NW];

endmodule

>>> rtl/line_extend_to_box_core.sv
// ----------------------------------------------------------------------------
// line_extend_to_box_core
// extends a segment to the border of a configured box
// ----------------------------------------------------------------------------
// Takes one segment per clock unless the output side stalls, and returns the
// two points where its line meets the box border. The pipeline has four front
// stages (input, differences, products, edge select), one stage per quotient
// bit of the 2*COORD_WIDTH+2 bit pipelined divider, and the output register.
// The whole pipeline advances whenever the output register is empty or taken,
// so s_tready follows m_tready. Box registers may only be written while idle.
module line_extend_to_box_core
	import lec_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_addr,
	input  logic [COORD_WIDTH-1:0]     cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// seg_start_x, seg_start_y, seg_end_x, seg_end_y
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// out_start_x, out_start_y, out_end_x, out_end_y
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int W   = COORD_WIDTH;
	localparam int TDW = ((4*W+7)/8)*8;
	localparam int DW  = W + 1;
	localparam int NW  = 2 * DW;
	localparam int SW  = NW + 2;
	localparam int PB  = 2*W + 2;
	localparam int PA  = PB + 2*W + 3;
	localparam logic signed [SW-1:0] CMAX_E = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] CMIN_E = ~CMAX_E;

	logic signed [W-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= W'(1048320);
			box_bottom_q <= W'(1048320);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_BOX_LEFT:   box_left_q   <= cfg_wdata;
				REG_BOX_TOP:    box_top_q    <= cfg_wdata;
				REG_BOX_RIGHT:  box_right_q  <= cfg_wdata;
				REG_BOX_BOTTOM: box_bottom_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic                vld_s1, vld_s2, vld_s3, vld_s4;

	pipe_ctl_t ctl;
	assign ctl.en  = ~m_tvalid | m_tready;
	assign ctl.vld = vld_s4;
	assign s_tready = ctl.en;

	// stage 1: capture
	logic signed [W-1:0] sx_s1, sy_s1, ex_s1, ey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sx_s1 <= s_tdata[W-1:0];
			sy_s1 <= s_tdata[2*W-1:W];
			ex_s1 <= s_tdata[3*W-1:2*W];
			ey_s1 <= s_tdata[4*W-1:3*W];
		end
	end

	// stage 2: differences and magnitudes
	logic signed [DW-1:0] gx, gy, dxa, dya, dxb, dyb;
	logic signed [W-1:0]  cxa, cya, cxb, cyb;
	logic                 fall;

	assign gx   = DW'(ex_s1) - DW'(sx_s1);
	assign gy   = DW'(ey_s1) - DW'(sy_s1);
	assign fall = gx[DW-1] ^ gy[DW-1];
	assign cxb  = box_right_q;
	assign cyb  = fall ? box_top_q : box_bottom_q;
	assign cxa  = box_left_q;
	assign cya  = fall ? box_bottom_q : box_top_q;
	assign dxa  = DW'(cxa) - DW'(sx_s1);
	assign dya  = DW'(cya) - DW'(sy_s1);
	assign dxb  = DW'(cxb) - DW'(sx_s1);
	assign dyb  = DW'(cyb) - DW'(sy_s1);

	function automatic logic [DW-1:0] magn(input logic signed [DW-1:0] v);
		magn = v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	logic [DW-1:0]       mgx_s2, mgy_s2, mdxa_s2, mdya_s2, mdxb_s2, mdyb_s2;
	logic [5:0]          sgn_s2, sgn_s3;
	logic signed [W-1:0] cxa_s2, cya_s2, cxb_s2, cyb_s2, cxa_s3, cya_s3, cxb_s3, cyb_s3;
	logic signed [W-1:0] sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4;
	logic [2:0]          flg_s2, flg_s3, flg_s4;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			mgx_s2  <= magn(gx);
			mgy_s2  <= magn(gy);
			mdxa_s2 <= magn(dxa);
			mdya_s2 <= magn(dya);
			mdxb_s2 <= magn(dxb);
			mdyb_s2 <= magn(dyb);
			sgn_s2  <= {gx[DW-1], gy[DW-1], dxa[DW-1], dya[DW-1], dxb[DW-1], dyb[DW-1]};
			cxa_s2  <= cxa;
			cya_s2  <= cya;
			cxb_s2  <= cxb;
			cyb_s2  <= cyb;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			flg_s2  <= {gx == '0, gy == '0, sx_s1 > ex_s1};
		end
	end

	// stage 3: cross products
	logic [NW-1:0] pa1_s3, pa2_s3, pb1_s3, pb2_s3;
	logic [DW-1:0] mgx_s3, mgy_s3;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			pa1_s3 <= NW'(mgy_s2) * NW'(mdxa_s2);
			pa2_s3 <= NW'(mdya_s2) * NW'(mgx_s2);
			pb1_s3 <= NW'(mgy_s2) * NW'(mdxb_s2);
			pb2_s3 <= NW'(mdyb_s2) * NW'(mgx_s2);
			mgx_s3 <= mgx_s2;
			mgy_s3 <= mgy_s2;
			sgn_s3 <= sgn_s2;
			cxa_s3 <= cxa_s2;
			cya_s3 <= cya_s2;
			cxb_s3 <= cxb_s2;
			cyb_s3 <= cyb_s2;
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
			flg_s3 <= flg_s2;
		end
	end

	// stage 4: edge choice
	logic                hza, hzb;
	logic [NW-1:0]       numa_s4, numb_s4;
	logic [DW-1:0]       dena_s4, denb_s4;
	logic [PB-1:0]       paya_s4, payb_s4;
	logic                sg_x, sg_y;

	assign hza  = pa1_s3 > pa2_s3;
	assign hzb  = pb1_s3 > pb2_s3;
	assign sg_x = sgn_s3[5];
	assign sg_y = sgn_s3[4];

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			numa_s4 <= hza ? pa2_s3 : pa1_s3;
			dena_s4 <= hza ? mgy_s3 : mgx_s3;
			paya_s4 <= {hza ? sx_s3 : sy_s3, hza ? cya_s3 : cxa_s3,
				hza ? (sg_x ^ sgn_s3[2] ^ sg_y) : (sg_y ^ sgn_s3[3] ^ sg_x), hza};
			numb_s4 <= hzb ? pb2_s3 : pb1_s3;
			denb_s4 <= hzb ? mgy_s3 : mgx_s3;
			payb_s4 <= {hzb ? sx_s3 : sy_s3, hzb ? cyb_s3 : cxb_s3,
				hzb ? (sg_x ^ sgn_s3[0] ^ sg_y) : (sg_y ^ sgn_s3[1] ^ sg_x), hzb};
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
			flg_s4  <= flg_s3;
		end
	end

	// quotients
	logic          vld_da, vld_db;
	logic [NW-1:0] qa, qb;
	logic [PA-1:0] pay_da;
	logic [PB-1:0] pay_db;

	lec_div #(.NW(NW), .DW(DW), .PW(PA)) u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.num     (numa_s4),
		.den     (dena_s4),
		.pay_in  ({sx_s4, sy_s4, flg_s4, paya_s4}),
		.vld_out (vld_da),
		.quo     (qa),
		.pay_out (pay_da)
	);

	lec_div #(.NW(NW), .DW(DW), .PW(PB)) u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.num     (numb_s4),
		.den     (denb_s4),
		.pay_in  (payb_s4),
		.vld_out (vld_db),
		.quo     (qb),
		.pay_out (pay_db)
	);

	function automatic logic [W-1:0] along(input logic signed [W-1:0] base,
		input logic [NW-1:0] q, input logic neg);
		logic signed [SW-1:0] be;
		logic signed [SW-1:0] qe;
		logic signed [SW-1:0] sum;
		be  = {{(SW-W){base[W-1]}}, base};
		qe  = {2'b00, q};
		sum = neg ? be - qe : be + qe;
		if (sum > CMAX_E) along = CMAX_E[W-1:0];
		else if (sum < CMIN_E) along = CMIN_E[W-1:0];
		else along = sum[W-1:0];
	endfunction

	// output stage
	logic signed [W-1:0] fsx, fsy, basea, fixa, baseb, fixb, ca, cb;
	logic                f_vert, f_horz, f_swap, nega, hza_d, negb, hzb_d;
	logic [W-1:0]        ax, ay, bx, by, oax, oay, obx, oby;
	logic                lr;

	assign {fsx, fsy, f_vert, f_horz, f_swap, basea, fixa, nega, hza_d} = pay_da;
	assign {baseb, fixb, negb, hzb_d} = pay_db;
	assign ca = along(basea, qa, nega);
	assign cb = along(baseb, qb, negb);
	assign ax = hza_d ? ca : fixa;
	assign ay = hza_d ? fixa : ca;
	assign bx = hzb_d ? cb : fixb;
	assign by = hzb_d ? fixb : cb;
	assign lr = box_left_q < box_right_q;

	always_comb begin
		if (f_vert) begin
			oax = fsx;
			oay = box_bottom_q;
			obx = fsx;
			oby = box_top_q;
		end else if (f_horz) begin
			oax = lr ? box_left_q : box_right_q;
			obx = lr ? box_right_q : box_left_q;
			oay = fsy;
			oby = fsy;
		end else if (f_swap) begin
			oax = bx;
			oay = by;
			obx = ax;
			oby = ay;
		end else begin
			oax = ax;
			oay = ay;
			obx = bx;
			oby = by;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ctl.en) begin
			m_tvalid <= vld_da & vld_db;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			m_tdata <= TDW'({oby, obx, oay, oax});
		end
	end

endmodule

>>> rtl/lec_checker.sv
// ----------------------------------------------------------------------------
// lec_checker
// port-level checks for the line extension core
// ----------------------------------------------------------------------------
module lec_checker
	import lec_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_we,
	input logic [1:0]                 cfg_addr,
	input logic [COORD_WIDTH-1:0]     cfg_wdata,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output side");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("output item appeared while pipeline stalled");

endmodule

bind line_extend_to_box_core lec_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lec_checker (.*);

>>> verif/tb_line_extend_to_box_core.sv
// ----------------------------------------------------------------------------
// tb_line_extend_to_box_core
// self-checking bench for the line extension core
// ----------------------------------------------------------------------------
// Segments are streamed into the core and each returned pair of border points
// is checked field by field against a fixed point model of the extension. A
// directed table covers vertical, horizontal, diagonal, reversed, degenerate
// and extreme segments after reset. Random phases follow, each with a box
// setting (reset, extremes, unordered, random) and a mix of sender idling
// and receiver stalls. Box registers are only written with the core drained.
// ----------------------------------------------------------------------------
module tb_line_extend_to_box_core;
	import lec_pkg::*;

	localparam int CW = 24;
	localparam int DW = 4 * CW;
	localparam int LATENCY = 2 * CW + 7;
	localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t sx, sy, ex, ey;
		bit     chk;
		coord_t ax, ay, bx, by;
	} seg_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_addr = REG_BOX_LEFT;
	logic [CW-1:0] cfg_wdata = '0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [DW-1:0] m_tdata;

	coord_t        box_l, box_t, box_r, box_b;
	logic [DW-1:0] border_pts_q[$];
	int            snd_idle, rcv_stall;
	int            n_mismatch = 0;

	seg_row_t seg_table[14] = '{
		'{100, 5, 100, 9, 1, 100, 1048320, 100, 0},
		'{-7, 33, -7, 33, 1, -7, 1048320, -7, 0},
		'{5, 200, 9, 200, 1, 0, 200, 1048320, 200},
		'{9, 200, 5, 200, 1, 0, 200, 1048320, 200},
		'{0, 0, 256, 256, 1, 0, 0, 1048320, 1048320},
		'{256, 256, 0, 0, 1, 1048320, 1048320, 0, 0},
		'{100, 900, 300, 100, 0, 0, 0, 0, 0},
		'{300, 100, 100, 900, 0, 0, 0, 0, 0},
		'{1048320, 0, 1000, 5000, 0, 0, 0, 0, 0},
		'{-8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0, 0},
		'{8388607, -8388608, -8388608, 8388607, 0, 0, 0, 0, 0},
		'{0, 0, 1, 8388607, 0, 0, 0, 0, 0},
		'{-8388608, 0, 8388607, 1, 0, 0, 0, 0, 0},
		'{50, 60, 51, -8388608, 0, 0, 0, 0, 0}
	};

	line_extend_to_box_core #(.COORD_WIDTH(CW)) uut (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint clamp(longint v);
		if (v > CMAX)
			return CMAX;
		if (v < CMIN)
			return CMIN;
		return v;
	endfunction

	// base + trunc(a*b/d), saturated
	function automatic longint offset_along(longint base, longint a, longint b, longint d);
		longint unsigned q;
		bit neg;
		neg = ((a < 0) != (b < 0)) != (d < 0);
		if (d == 0)
			return clamp(base);
		q = mag(a) * mag(b) / mag(d);
		if (q > (64'd1 << 40))
			return neg ? CMIN : CMAX;
		return clamp(neg ? base - longint'(q) : base + longint'(q));
	endfunction

	function automatic void corner_hit(longint sx, longint sy, longint gx, longint gy,
			longint cx, longint cy, output longint px, output longint py);
		longint dx, dy;
		dx = cx - sx;
		dy = cy - sy;
		if (mag(gy) * mag(dx) > mag(dy) * mag(gx)) begin
			px = offset_along(sx, gx, dy, gy);
			py = cy;
		end else begin
			px = cx;
			py = offset_along(sy, gy, dx, gx);
		end
	endfunction

	function automatic logic [DW-1:0] extend_to_box(logic [DW-1:0] seg);
		longint sx, sy, ex, ey, l, t, r, b, gx, gy, ax, ay, bx, by, tmp;
		coord_t oax, oay, obx, oby;
		sx = coord_t'(seg[0*CW +: CW]);
		sy = coord_t'(seg[1*CW +: CW]);
		ex = coord_t'(seg[2*CW +: CW]);
		ey = coord_t'(seg[3*CW +: CW]);
		l = box_l;
		t = box_t;
		r = box_r;
		b = box_b;
		gx = ex - sx;
		gy = ey - sy;
		if (gx == 0) begin
			ax = sx; ay = b; bx = sx; by = t;
		end else if (gy == 0) begin
			ax = l < r ? l : r;
			bx = l < r ? r : l;
			ay = sy; by = sy;
		end else begin
			if ((gx < 0) != (gy < 0)) begin
				corner_hit(sx, sy, gx, gy, r, t, bx, by);
				corner_hit(sx, sy, gx, gy, l, b, ax, ay);
			end else begin
				corner_hit(sx, sy, gx, gy, r, b, bx, by);
				corner_hit(sx, sy, gx, gy, l, t, ax, ay);
			end
			if (sx > ex) begin
				tmp = ax; ax = bx; bx = tmp;
				tmp = ay; ay = by; by = tmp;
			end
		end
		oax = ax[CW-1:0];
		oay = ay[CW-1:0];
		obx = bx[CW-1:0];
		oby = by[CW-1:0];
		return {oby, obx, oay, oax};
	endfunction

	function automatic coord_t pick_coord(int kind);
		case ($urandom_range(3))
			0: return kind == 4 ? coord_t'(CMIN) : coord_t'($urandom_range(8191)) - 24'sd4096;
			1: return kind == 4 ? coord_t'(CMAX) : coord_t'($urandom_range(1048320));
			2: return kind == 4 ? coord_t'(0) : coord_t'($urandom);
			default: return kind == 4 ? coord_t'(-1) : coord_t'($urandom_range(300000));
		endcase
	endfunction

	function automatic logic [DW-1:0] random_seg();
		int kind;
		coord_t sx, sy, ex, ey;
		kind = $urandom_range(9);
		sx = pick_coord(kind);
		sy = pick_coord(kind);
		ex = pick_coord(kind);
		ey = pick_coord(kind);
		if (kind >= 6) begin
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
		end
		if (kind == 1)
			ex = sx;
		if (kind == 2)
			ey = sy;
		if (kind == 3) begin
			ex = sx; ey = sy;
		end
		return {ey, ex, sy, sx};
	endfunction

	task automatic push_seg(logic [DW-1:0] seg);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= seg;
		do
			@(posedge clk);
		while (!s_tready);
		border_pts_q.push_back(extend_to_box(seg));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (border_pts_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_box(coord_t l, coord_t t, coord_t r, coord_t b);
		reg_idx_t idx;
		coord_t vals[4];
		vals = '{l, t, r, b};
		for (int i = 0; i < 4; i++) begin
			idx = reg_idx_t'(i);
			cfg_we <= 1'b1;
			cfg_addr <= idx;
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		box_l = l; box_t = t; box_r = r; box_b = b;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= $urandom_range(99) >= rcv_stall;
	end

	always @(posedge clk) begin
		logic [DW-1:0] want;
		if (m_tvalid && m_tready) begin
			if (border_pts_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected item %h", m_tdata);
			end else begin
				want = border_pts_q.pop_front();
				for (int f = 0; f < 4; f++) begin
					if (m_tdata[f*CW +: CW] !== want[f*CW +: CW]) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("field %0d mismatch: exp %0d got %0d", f,
								coord_t'(want[f*CW +: CW]), coord_t'(m_tdata[f*CW +: CW]));
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		snd_idle = 0;
		rcv_stall = 0;
		box_l = 0; box_t = 0; box_r = 1048320; box_b = 1048320;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (seg_table[i]) begin
			push_seg({seg_table[i].ey, seg_table[i].ex, seg_table[i].sy, seg_table[i].sx});
			if (seg_table[i].chk && border_pts_q[$] !== {seg_table[i].by, seg_table[i].bx,
					seg_table[i].ay, seg_table[i].ax}) begin
				n_mismatch++;
				$display("table row %0d predicts %h", i, border_pts_q[$]);
			end
		end
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				1: write_box(coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMAX));
				2: write_box(coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN));
				3: write_box(-24'sd2560, 24'sd1280, 24'sd5120, -24'sd768);
				4: write_box(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom));
				5: write_box(24'sd0, 24'sd0, 24'sd1048320, 24'sd1048320);
				default: ;
			endcase
			snd_idle = (ph % 4 == 1) ? 77 : (ph % 4 == 3) ? 29 : 0;
			rcv_stall = (ph % 4 == 2) ? 77 : (ph % 4 == 3) ? 29 : 0;
			repeat (100) push_seg(random_seg());
		end
		s_tvalid <= 1'b0;
		while (border_pts_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (n_mismatch == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
